>>> src/kmdr_pkg.sv
// ----------------------------------------------------------------------------
// kmdr_pkg
// Shared types, constants and helpers for the keyboard matrix debounce and
// auto-repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmdr_pkg;

   // matrix geometry
   localparam int NUM_COLS  = 10;
   localparam int SHIFT_COL = 8;
   localparam int FKEY_COL  = 9;

   // code constants
   localparam logic [7:0] COL_IDLE     = 8'hff;
   localparam logic [7:0] BREAK_MASK   = 8'h7f;
   localparam logic [7:0] CODE_NONE    = 8'h00;
   localparam logic [7:0] CODE_ESCAPE  = 8'h1b;
   localparam logic [7:0] SHIFT_MARK   = 8'h80;

   // register reset values
   localparam logic [7:0] WINDOW_RESET = 8'd8;
   localparam logic [7:0] DELAY_RESET  = 8'd64;
   localparam logic [7:0] RATE_RESET   = 8'd6;

   // configuration register indices
   typedef enum logic [1:0] {
      CSR_WINDOW_LENGTH = 2'd0,
      CSR_REPEAT_DELAY  = 2'd1,
      CSR_REPEAT_RATE   = 2'd2
   } csr_index_type;

   // what one column lane reports for the current scan
   typedef struct packed {
      logic changed;
      logic any;
      logic fresh;
   } lane_flags_type;

   // one result beat
   typedef struct packed {
      logic [7:0] key_code;
      logic       shift_down;
      logic       any_key_seen;
   } result_type;

   // function key number from the pressed bits of the function column
   function automatic logic [7:0] fkey_number(input logic [7:0] pressed);
      logic [7:0] num;
      if (pressed[7]) begin
         num = 8'd1;
      end else if (pressed[6]) begin
         num = 8'd2;
      end else if (pressed[5]) begin
         num = 8'd3;
      end else if (pressed[4]) begin
         num = 8'd4;
      end else if (pressed[3]) begin
         num = 8'd5;
      end else begin
         num = 8'd0;
      end
      return num;
   endfunction

endpackage

`default_nettype wire

>>> src/kmdr_lane.sv
// ----------------------------------------------------------------------------
// kmdr_lane
// One column lane: holds the previous and last evaluated row bits of its
// column and flags change, key down and new press for the current scan.
// ----------------------------------------------------------------------------
`default_nettype none

module kmdr_lane (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic                     eval_load,
   input  wire logic [7:0]               col,
   output kmdr_pkg::lane_flags_type      flags
);

   logic [7:0] previous_ff;
   logic [7:0] previous_in;
   logic [7:0] evaluated_ff;
   logic [7:0] evaluated_in;

   // compare the scan against the stored copies
   always_comb begin
      flags.changed = (previous_ff != col);
      flags.any     = (col != kmdr_pkg::COL_IDLE);
      flags.fresh   = ((~col & evaluated_ff) != 8'd0);
   end

   // advance the stored copies
   always_comb begin
      previous_in  = accept    ? col : previous_ff;
      evaluated_in = eval_load ? col : evaluated_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_ff  <= kmdr_pkg::COL_IDLE;
         evaluated_ff <= kmdr_pkg::COL_IDLE;
      end else begin
         previous_ff  <= previous_in;
         evaluated_ff <= evaluated_in;
      end
   end

endmodule

`default_nettype wire

>>> src/kmdr_merge.sv
// ----------------------------------------------------------------------------
// kmdr_merge
// Merge the lane flags, run the debounce window and the auto-repeat
// counter, hold the configuration registers and form the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module kmdr_merge (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire logic                                           accept,
   input  wire kmdr_pkg::lane_flags_type [kmdr_pkg::NUM_COLS-1:0] lane_flags,
   input  wire logic [7:0]                                     fkey_col,
   input  wire logic                                           shift_raw,
   input  wire logic [7:0]                                     decoded_key,
   input  wire logic                                           csr_write,
   input  wire logic [1:0]                                     csr_index,
   input  wire logic [7:0]                                     csr_data,
   output logic                                                eval_load,
   output kmdr_pkg::result_type                                result
);

   logic [7:0] window_ff,  window_in;
   logic [7:0] delay_ff,   delay_in;
   logic [7:0] rate_ff,    rate_in;
   logic [7:0] stable_ff,  stable_in;
   logic [7:0] repeat_ff,  repeat_in;
   logic [7:0] held_ff,    held_in;
   logic       shift_ff,   shift_in;
   logic       any_ff,     any_in;

   logic                          changed;
   logic                          any;
   logic                          fresh;
   logic [kmdr_pkg::NUM_COLS-1:0] changed_vec;
   logic [kmdr_pkg::NUM_COLS-1:0] any_vec;
   logic [kmdr_pkg::NUM_COLS-1:0] fresh_vec;
   logic                          eval_fire;
   logic [7:0]                    repeat_dec;
   logic [7:0]                    code;

   // gather the lane flags
   always_comb begin
      for (int i = 0; i < kmdr_pkg::NUM_COLS; i++) begin
         changed_vec[i] = lane_flags[i].changed;
         any_vec[i]     = lane_flags[i].any;
         fresh_vec[i]   = lane_flags[i].fresh;
      end
      changed = |changed_vec;
      any     = |any_vec;
      fresh   = |fresh_vec;
   end

   // configuration writes
   always_comb begin
      window_in = window_ff;
      delay_in  = delay_ff;
      rate_in   = rate_ff;
      if (csr_write) begin
         case (csr_index)
            kmdr_pkg::CSR_WINDOW_LENGTH: window_in = csr_data;
            kmdr_pkg::CSR_REPEAT_DELAY:  delay_in  = csr_data;
            kmdr_pkg::CSR_REPEAT_RATE:   rate_in   = csr_data;
            default: ;
         endcase
      end
   end

   // debounce window, evaluation and repeat
   always_comb begin
      stable_in  = stable_ff;
      repeat_in  = repeat_ff;
      held_in    = held_ff;
      shift_in   = shift_ff;
      any_in     = any_ff;
      eval_fire  = 1'b0;
      eval_load  = 1'b0;
      code       = kmdr_pkg::CODE_NONE;
      repeat_dec = repeat_ff - 8'd1;
      if (accept) begin
         shift_in = ~shift_raw;
         if (changed) begin
            stable_in = 8'd0;
         end else if (stable_ff < window_ff) begin
            stable_in = stable_ff + 8'd1;
         end else begin
            stable_in = 8'd0;
            eval_fire = 1'b1;
            any_in    = any;
            if (!any) begin
               eval_load = 1'b1;
               held_in   = kmdr_pkg::CODE_NONE;
               repeat_in = delay_ff;
            end else if (fresh) begin
               eval_load = 1'b1;
               repeat_in = delay_ff;
               if (fresh_vec[kmdr_pkg::FKEY_COL]) begin
                  held_in = kmdr_pkg::CODE_NONE;
                  code    = kmdr_pkg::fkey_number(~fkey_col) |
                            (shift_in ? kmdr_pkg::SHIFT_MARK : 8'd0);
               end else if (fresh_vec[kmdr_pkg::SHIFT_COL]) begin
                  held_in = kmdr_pkg::CODE_NONE;
                  code    = kmdr_pkg::CODE_ESCAPE;
               end else begin
                  held_in = decoded_key;
                  code    = decoded_key;
               end
            end else if (held_ff != kmdr_pkg::CODE_NONE) begin
               if (repeat_dec == 8'd0) begin
                  repeat_in = rate_ff;
                  code      = held_ff;
               end else begin
                  repeat_in = repeat_dec;
               end
            end
         end
      end
   end

   always_comb begin
      result.key_code     = code;
      result.shift_down   = shift_in;
      result.any_key_seen = any_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= kmdr_pkg::WINDOW_RESET;
         delay_ff  <= kmdr_pkg::DELAY_RESET;
         rate_ff   <= kmdr_pkg::RATE_RESET;
         stable_ff <= 8'd0;
         repeat_ff <= kmdr_pkg::DELAY_RESET;
         held_ff   <= kmdr_pkg::CODE_NONE;
         shift_ff  <= 1'b0;
         any_ff    <= 1'b1;
      end else begin
         window_ff <= window_in;
         delay_ff  <= delay_in;
         rate_ff   <= rate_in;
         stable_ff <= stable_in;
         repeat_ff <= repeat_in;
         held_ff   <= held_in;
         shift_ff  <= shift_in;
         any_ff    <= any_in;
      end
   end

`ifndef ASSERT_OFF
   a_load_on_eval: assert property (@(posedge clock) disable iff (reset)
      eval_load |-> (accept && eval_fire && !changed))
      else $error("evaluated scan loaded outside an evaluation");

   a_change_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && changed) |=> (stable_ff == 8'd0))
      else $error("scan change did not restart the debounce window");

   a_code_needs_eval: assert property (@(posedge clock) disable iff (reset)
      (accept && (code != kmdr_pkg::CODE_NONE)) |-> eval_fire)
      else $error("key reported without an evaluation");
`endif

endmodule

`default_nettype wire

>>> src/kmdr_out.sv
// ----------------------------------------------------------------------------
// kmdr_out
// Output register with a skid stage: takes a result beat every cycle while
// the skid stage is empty and asks for a stall only once it is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module kmdr_out (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire kmdr_pkg::result_type  push_data,
   output logic                       full,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output kmdr_pkg::result_type       rsp_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   kmdr_pkg::result_type main_ff,       main_in;
   kmdr_pkg::result_type skid_ff,       skid_in;
   logic                 pop;

   assign pop       = main_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   // steer the beat into the output register or the skid stage
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef ASSERT_OFF
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage holds a beat while the output register is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && skid_valid_ff))
      else $error("beat pushed into a full output stage");
`endif

endmodule

`default_nettype wire

>>> src/key_matrix_debounce_repeat_top.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_repeat_top
// Keyboard matrix debounce and auto-repeat, one full matrix scan per beat.
// ----------------------------------------------------------------------------
// Each request beat carries one scan of ten active-low columns and the code
// an external decoder gives for it; each request yields exactly one response
// beat, in order. One scan is taken every clock while req_stall is low: ten
// column lanes compare the scan against their stored copies in parallel and
// a merge stage runs the debounce window and repeat counter in the same cycle.
// The response is registered in an output register with a skid stage behind
// it, so req_stall rises only after two responses are held back.
// Registers are written through the csr_ port (always ready) and should be
// changed only while no response is pending; index 3 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_repeat_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_column_0,
   input  wire logic [7:0]  req_column_1,
   input  wire logic [7:0]  req_column_2,
   input  wire logic [7:0]  req_column_3,
   input  wire logic [7:0]  req_column_4,
   input  wire logic [7:0]  req_column_5,
   input  wire logic [7:0]  req_column_6,
   input  wire logic [7:0]  req_column_7,
   input  wire logic [7:0]  req_column_8,
   input  wire logic [7:0]  req_column_9,
   input  wire logic [7:0]  req_decoded_key,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_key_code,
   output logic             rsp_shift_down,
   output logic             rsp_any_key_seen,
   // configuration port
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   logic                                              accept;
   logic                                              eval_load;
   logic [7:0]                                        cur [kmdr_pkg::NUM_COLS];
   kmdr_pkg::lane_flags_type [kmdr_pkg::NUM_COLS-1:0] lane_flags;
   kmdr_pkg::result_type                              result;
   kmdr_pkg::result_type                              rsp_data;
   logic                                              out_full;

   assign accept    = req_valid && !req_stall;
   assign req_stall = out_full;
   assign csr_ready = 1'b1;

   // condition the scan: the shift column keeps only its break bit
   always_comb begin
      cur[0] = req_column_0;
      cur[1] = req_column_1;
      cur[2] = req_column_2;
      cur[3] = req_column_3;
      cur[4] = req_column_4;
      cur[5] = req_column_5;
      cur[6] = req_column_6;
      cur[7] = req_column_7;
      cur[8] = req_column_8 | kmdr_pkg::BREAK_MASK;
      cur[9] = req_column_9;
   end

   // one lane per column
   for (genvar g = 0; g < kmdr_pkg::NUM_COLS; g++) begin : g_lane
      kmdr_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .eval_load (eval_load),
         .col       (cur[g]),
         .flags     (lane_flags[g])
      );
   end

   kmdr_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .lane_flags  (lane_flags),
      .fkey_col    (cur[kmdr_pkg::FKEY_COL]),
      .shift_raw   (req_column_8[0]),
      .decoded_key (req_decoded_key),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .eval_load   (eval_load),
      .result      (result)
   );

   kmdr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_key_code     = rsp_data.key_code;
   assign rsp_shift_down   = rsp_data.shift_down;
   assign rsp_any_key_seen = rsp_data.any_key_seen;

endmodule

`default_nettype wire

>>> bench/key_matrix_debounce_repeat_top_tb.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_repeat_top_tb
// Self-checking bench for the keyboard matrix debounce and auto-repeat block.
// Scans are pushed through the request channel with random gaps. Every scan
// is run through a local debounce and repeat predictor, and every response
// beat is compared with the oldest expected report. The run steps through
// several register settings, from a zero window with wrapping repeat counts
// up to the widest window.
// ----------------------------------------------------------------------------
import kmdr_pkg::*;

module key_matrix_debounce_repeat_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         REPORT_LIMIT     = 10;
   localparam int         STALL_LIMIT      = 1000;
   localparam int         HOLD_OFF_CYCLES  = 80;
   localparam int         SETTLE_CYCLES    = 3;
   localparam int         TAIL_CYCLES      = 10;
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;

   // one scan of the matrix plus the decoder's code for it
   typedef struct packed {
      logic [NUM_COLS-1:0][7:0] col;
      logic [7:0]               decoded;
   } scan_beat_type;

   // predicts one report per scan and checks the response beats in order
   class keyscan_scoreboard;
      logic [7:0]               window_len;
      logic [7:0]               delay_len;
      logic [7:0]               rate_len;
      logic [NUM_COLS-1:0][7:0] last_scan;
      logic [NUM_COLS-1:0][7:0] judged_scan;
      logic [7:0]               settle_cnt;
      logic [7:0]               repeat_cnt;
      logic [7:0]               repeat_code;
      logic                     shift_seen;
      logic                     any_seen;
      result_type               expected_q[$];
      int failures;
      int results_checked;
      int scans_noted;
      int key_reports;
      int repeat_reports;
      int fkey_reports;
      int escape_reports;

      function new();
         window_len  = WINDOW_RESET;
         delay_len   = DELAY_RESET;
         rate_len    = RATE_RESET;
         last_scan   = {NUM_COLS{COL_IDLE}};
         judged_scan = {NUM_COLS{COL_IDLE}};
         settle_cnt  = 8'd0;
         repeat_cnt  = DELAY_RESET;
         repeat_code = CODE_NONE;
         shift_seen  = 1'b0;
         any_seen    = 1'b1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] value);
         case (idx)
            CSR_WINDOW_LENGTH: window_len = value;
            CSR_REPEAT_DELAY:  delay_len  = value;
            CSR_REPEAT_RATE:   rate_len   = value;
            default: ;
         endcase
      endfunction

      // highest pressed bit among F1 (bit 7) to F5 (bit 3)
      function logic [7:0] fkey_rank(logic [7:0] pressed);
         logic [7:0] rank;
         rank = CODE_NONE;
         for (int b = 3; b <= 7; b++) begin
            if (pressed[b]) begin
               rank = 8'(8 - b);
            end
         end
         return rank;
      endfunction

      function void note_scan(scan_beat_type s);
         logic [NUM_COLS-1:0][7:0] cur;
         logic [7:0]               c;
         logic [7:0]               code;
         bit                       moved;
         bit                       any_down;
         bit                       new_press;
         bit                       new_fkey;
         bit                       new_break;
         result_type               want;
         moved     = 1'b0;
         any_down  = 1'b0;
         new_press = 1'b0;
         new_fkey  = 1'b0;
         new_break = 1'b0;
         code      = CODE_NONE;
         // compare every column lane; column 8 gives shift, then keeps break only
         for (int i = 0; i < NUM_COLS; i++) begin
            c = s.col[i];
            if (i == SHIFT_COL) begin
               shift_seen = ~c[0];
               c = c | BREAK_MASK;
            end
            cur[i] = c;
            if (last_scan[i] != c) begin
               moved = 1'b1;
            end
            last_scan[i] = c;
            if (c != COL_IDLE) begin
               any_down = 1'b1;
            end
            if ((~c & judged_scan[i]) != 8'd0) begin
               new_press = 1'b1;
               if (i == FKEY_COL) begin
                  new_fkey = 1'b1;
               end
               if (i == SHIFT_COL) begin
                  new_break = 1'b1;
               end
            end
         end
         // debounce window, then judge the settled scan
         if (moved) begin
            settle_cnt = 8'd0;
         end else if (settle_cnt < window_len) begin
            settle_cnt = settle_cnt + 8'd1;
         end else begin
            settle_cnt = 8'd0;
            any_seen   = any_down;
            if (!any_down) begin
               judged_scan = cur;
               repeat_code = CODE_NONE;
               repeat_cnt  = delay_len;
            end else if (new_press) begin
               judged_scan = cur;
               repeat_cnt  = delay_len;
               if (new_fkey) begin
                  repeat_code = CODE_NONE;
                  code = fkey_rank(~cur[FKEY_COL]) + (shift_seen ? SHIFT_MARK : CODE_NONE);
                  fkey_reports++;
               end else if (new_break) begin
                  repeat_code = CODE_NONE;
                  code = CODE_ESCAPE;
                  escape_reports++;
               end else begin
                  repeat_code = s.decoded;
                  code = s.decoded;
                  key_reports++;
               end
            end else if (repeat_code != CODE_NONE) begin
               repeat_cnt = repeat_cnt - 8'd1;
               if (repeat_cnt == 8'd0) begin
                  repeat_cnt = rate_len;
                  code = repeat_code;
                  repeat_reports++;
               end
            end
         end
         want.key_code     = code;
         want.shift_down   = shift_seen;
         want.any_key_seen = any_seen;
         expected_q.push_back(want);
         scans_noted++;
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("unexpected response: key_code %02h shift_down %0b any_key_seen %0b",
                        got.key_code, got.shift_down, got.any_key_seen);
            end
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         if (got.key_code !== want.key_code || got.shift_down !== want.shift_down ||
             got.any_key_seen !== want.any_key_seen) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("mismatch on response %0d: key_code exp %02h got %02h, %s",
                        results_checked, want.key_code, got.key_code,
                        $sformatf("shift_down exp %0b got %0b, any_key_seen exp %0b got %0b",
                                  want.shift_down, got.shift_down,
                                  want.any_key_seen, got.any_key_seen));
            end
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_column_0;
   logic [7:0] req_column_1;
   logic [7:0] req_column_2;
   logic [7:0] req_column_3;
   logic [7:0] req_column_4;
   logic [7:0] req_column_5;
   logic [7:0] req_column_6;
   logic [7:0] req_column_7;
   logic [7:0] req_column_8;
   logic [7:0] req_column_9;
   logic [7:0] req_decoded_key;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_key_code;
   logic       rsp_shift_down;
   logic       rsp_any_key_seen;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_data;

   keyscan_scoreboard board = new();
   bit source_busy  = 1'b0;
   bit sink_busy    = 1'b0;
   bit hold_off_now = 1'b0;
   int settings_used = 0;
   int idle_cycles   = 0;

   key_matrix_debounce_repeat_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_column_0     (req_column_0),
      .req_column_1     (req_column_1),
      .req_column_2     (req_column_2),
      .req_column_3     (req_column_3),
      .req_column_4     (req_column_4),
      .req_column_5     (req_column_5),
      .req_column_6     (req_column_6),
      .req_column_7     (req_column_7),
      .req_column_8     (req_column_8),
      .req_column_9     (req_column_9),
      .req_decoded_key  (req_decoded_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_code     (rsp_key_code),
      .rsp_shift_down   (rsp_shift_down),
      .rsp_any_key_seen (rsp_any_key_seen),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- scans

   function automatic scan_beat_type quiet_scan(logic [7:0] dec);
      scan_beat_type s;
      s.col     = {NUM_COLS{COL_IDLE}};
      s.decoded = dec;
      return s;
   endfunction

   // one ordinary key down with a non-zero decoded code
   function automatic scan_beat_type make_key_scan();
      scan_beat_type s;
      int            k;
      int            b;
      s = quiet_scan(8'($urandom_range(1, 255)));
      k = $urandom_range(0, 7);
      b = $urandom_range(0, 7);
      s.col[k][b] = 1'b0;
      return s;
   endfunction

   function automatic scan_beat_type make_press_scan();
      scan_beat_type s;
      int            pick;
      int            k;
      int            b;
      s = quiet_scan(($urandom_range(0, 9) == 0) ? CODE_NONE : 8'($urandom));
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, 7);
      b = $urandom_range(0, 7);
      case (pick)
         0, 1, 2, 3: begin
            s.col[k][b] = 1'b0;
         end
         4: begin
            s.col[k][b] = 1'b0;
            s.col[$urandom_range(0, 7)][$urandom_range(0, 7)] = 1'b0;
         end
         5: begin
            if ($urandom_range(0, 1) == 0) begin
               s.col[FKEY_COL][$urandom_range(3, 7)] = 1'b0;
            end else begin
               s.col[FKEY_COL] = 8'($urandom);
            end
         end
         6: begin
            s.col[SHIFT_COL][7] = 1'b0;
         end
         7: begin
            s.col[k][b] = 1'b0;
            s.col[SHIFT_COL][7] = 1'b0;
            s.col[FKEY_COL][$urandom_range(0, 7)] = 1'b0;
         end
         8: begin
            for (int i = 0; i < NUM_COLS; i++) begin
               s.col[i] = 8'($urandom);
            end
         end
         default: ;
      endcase
      if ($urandom_range(0, 2) == 0) begin
         s.col[SHIFT_COL][0] = 1'b0;
      end
      return s;
   endfunction

   // wobble the bits of column 8 that the block masks off, shift included
   function automatic scan_beat_type jiggle(scan_beat_type s);
      s.col[SHIFT_COL][6:0] = 7'($urandom);
      return s;
   endfunction

   // --------------------------------------------------------------- drivers

   task automatic send_scan(scan_beat_type s);
      int gap;
      if ($urandom_range(0, 39) == 0) begin
         source_busy = ~source_busy;
      end
      gap = source_busy ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_column_9, req_column_8, req_column_7, req_column_6, req_column_5,
       req_column_4, req_column_3, req_column_2, req_column_1, req_column_0} <= s.col;
      req_decoded_key <= s.decoded;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_scan(s);
   endtask

   task automatic hold_scan(scan_beat_type s, int beats, bit wobble);
      repeat (beats) send_scan(wobble ? jiggle(s) : s);
   endtask

   // drop valid and wait until every report is back
   task automatic quiesce();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(logic [1:0] idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, value);
   endtask

   task automatic apply_settings(logic [7:0] win, logic [7:0] dly, logic [7:0] rate,
                                 bit poke_unused);
      quiesce();
      csr_beat(CSR_WINDOW_LENGTH, win);
      csr_beat(CSR_REPEAT_DELAY, dly);
      csr_beat(CSR_REPEAT_RATE, rate);
      if (poke_unused) begin
         csr_beat(CSR_UNUSED_INDEX, 8'($urandom));
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // well-formed holds with bounce, short broken holds and raw noise
   task automatic play_phase(int budget, int long_extra);
      int            left;
      int            style;
      int            span;
      int            beats;
      scan_beat_type target;
      left = budget;
      span = int'(board.window_len) + 2;
      while (left > 0) begin
         target = make_press_scan();
         style  = $urandom_range(0, 9);
         if (style < 7) begin
            repeat ($urandom_range(0, 2)) begin
               send_scan(make_press_scan());
               send_scan(jiggle(target));
               left -= 2;
            end
            beats = span + $urandom_range(0, long_extra);
         end else if (style < 9) begin
            beats = $urandom_range(1, span - 1);
         end else begin
            repeat (3) begin
               send_scan(make_press_scan());
            end
            left -= 3;
            beats = 0;
         end
         hold_scan(target, beats, 1'b1);
         left -= beats;
      end
   endtask

   // ---------------------------------------------------------------- sink

   initial begin : result_sink
      int         hold;
      result_type got;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // long hold-off so the block fills and back-pressures its input
         if (hold_off_now) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_now = 1'b0;
         end
         if ($urandom_range(0, 39) == 0) begin
            sink_busy = ~sink_busy;
         end
         hold = sink_busy ? 0 : $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.key_code     = rsp_key_code;
         got.shift_down   = rsp_shift_down;
         got.any_key_seen = rsp_any_key_seen;
         board.check_result(got);
      end
   end

   // ------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", idle_cycles);
            $display("key_matrix_debounce_repeat_top_tb failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------- sequence

   initial begin : stimulus
      scan_beat_type s;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_column_0    <= COL_IDLE;
      req_column_1    <= COL_IDLE;
      req_column_2    <= COL_IDLE;
      req_column_3    <= COL_IDLE;
      req_column_4    <= COL_IDLE;
      req_column_5    <= COL_IDLE;
      req_column_6    <= COL_IDLE;
      req_column_7    <= COL_IDLE;
      req_column_8    <= COL_IDLE;
      req_column_9    <= COL_IDLE;
      req_decoded_key <= CODE_NONE;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_WINDOW_LENGTH;
      csr_data        <= 8'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: zero window, so the second identical beat is judged
      apply_settings(8'd0, 8'd2, 8'd1, 1'b0);
      hold_scan(quiet_scan(CODE_NONE), 2, 1'b0);
      // plain key, held long enough for two repeats
      s = quiet_scan(8'h61);
      s.col[0] = 8'hfe;
      hold_scan(s, 5, 1'b0);
      // F1 with shift
      s = quiet_scan(8'h31);
      s.col[FKEY_COL]  = 8'h7f;
      s.col[SHIFT_COL] = 8'hfe;
      hold_scan(s, 2, 1'b0);
      // function key, break and plain key together: function key wins
      s = quiet_scan(8'h41);
      s.col[FKEY_COL]  = 8'hbf;
      s.col[SHIFT_COL] = 8'h7f;
      s.col[3]         = 8'hef;
      hold_scan(s, 2, 1'b0);
      // every row of every column down
      s.col     = '0;
      s.decoded = CODE_NONE;
      hold_scan(s, 3, 1'b0);
      hold_scan(quiet_scan(CODE_NONE), 2, 1'b0);
      // break beats a plain key
      s = quiet_scan(8'h42);
      s.col[SHIFT_COL] = 8'h7e;
      s.col[5]         = 8'hfd;
      hold_scan(s, 2, 1'b0);
      // decoded code zero never repeats
      s = quiet_scan(CODE_NONE);
      s.col[6] = 8'hbf;
      hold_scan(s, 4, 1'b0);
      // function column with only the unused low bits down, shifted
      s = quiet_scan(8'h55);
      s.col[FKEY_COL]  = 8'hfe;
      s.col[SHIFT_COL] = 8'hfe;
      hold_scan(s, 2, 1'b0);
      s = quiet_scan(8'hff);
      s.col[7] = 8'h7f;
      hold_scan(s, 2, 1'b0);

      // reset values
      apply_settings(WINDOW_RESET, DELAY_RESET, RATE_RESET, 1'b0);
      play_phase(120, 20);

      // short window with quick repeats, under a long response hold-off
      apply_settings(8'd1, 8'd3, 8'd2, 1'b0);
      hold_off_now = 1'b1;
      source_busy  = 1'b1;
      play_phase(200, 40);

      // narrowest settings; pause mid-phase until the block drains
      apply_settings(8'd0, 8'd1, 8'd1, 1'b0);
      play_phase(100, 20);
      quiesce();
      play_phase(100, 20);

      // widest window and slowest repeat
      apply_settings(8'd255, 8'd255, 8'd255, 1'b0);
      hold_scan(make_key_scan(), 260, 1'b1);
      hold_scan(quiet_scan(CODE_NONE), 3, 1'b0);

      // zero delay wraps the repeat count; the unused index must be ignored
      apply_settings(8'd0, 8'd0, 8'd0, 1'b1);
      hold_scan(quiet_scan(CODE_NONE), 2, 1'b0);
      hold_scan(make_key_scan(), 262, 1'b1);

      // zero rate wraps after the first repeat
      apply_settings(8'd0, 8'd1, 8'd0, 1'b0);
      hold_scan(quiet_scan(CODE_NONE), 2, 1'b0);
      hold_scan(make_key_scan(), 262, 1'b1);

      // a couple of random middle settings
      repeat (2) begin
         apply_settings(8'd2, 8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)), 1'b0);
         play_phase(60, 30);
      end

      quiesce();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d scans over %0d register settings: %0d key reports, %s",
               board.scans_noted, settings_used, board.key_reports,
               $sformatf("%0d repeats, %0d function keys, %0d escapes.",
                         board.repeat_reports, board.fkey_reports, board.escape_reports));
      $display("Checked %0d responses, %0d failures, %0d reports outstanding.",
               board.results_checked, board.failures, board.pending());
      if (board.failures == 0 && board.pending() == 0) begin
         $display("key_matrix_debounce_repeat_top_tb passed");
      end else begin
         $display("key_matrix_debounce_repeat_top_tb failed");
      end
      $finish;
   end

endmodule
